>>> hw/rtl/apfc_pkg.sv
package apfc_pkg;

  // Largest canvas or region side in pixels.
  localparam int unsigned MAX_SIDE = 512;
  // Address width of one canvas-sized store.
  localparam int unsigned ADDR_W   = $clog2(MAX_SIDE * MAX_SIDE);
  localparam int unsigned PIX_W    = 32;

  // Input word modes.
  localparam logic [1:0] MODE_FRAME   = 2'd0;
  localparam logic [1:0] MODE_READ    = 2'd1;
  localparam logic [1:0] MODE_DISPOSE = 2'd2;

  // Dispose modes.
  localparam logic [1:0] DISP_NONE    = 2'd0;
  localparam logic [1:0] DISP_CLEAR   = 2'd1;
  localparam logic [1:0] DISP_RESTORE = 2'd2;

  // Register indexes on the configuration port.
  localparam logic [2:0] REG_CANVAS_W = 3'd0;
  localparam logic [2:0] REG_CANVAS_H = 3'd1;
  localparam logic [2:0] REG_X_OFF    = 3'd2;
  localparam logic [2:0] REG_Y_OFF    = 3'd3;
  localparam logic [2:0] REG_FRAME_W  = 3'd4;
  localparam logic [2:0] REG_FRAME_H  = 3'd5;
  localparam logic [2:0] REG_BLEND    = 3'd6;
  localparam logic [2:0] REG_DISPOSE  = 3'd7;

  // Divider handshake between the sequencer and the dividers.
  typedef struct packed {
    logic start;
  } div_ctrl_t;

  // Clamp a side length to the largest supported side.
  function automatic logic [9:0] side_sat(input logic [9:0] v);
    logic [9:0] r;
    r = (v > 10'(MAX_SIDE)) ? 10'(MAX_SIDE) : v;
    return r;
  endfunction

endpackage

>>> hw/rtl/apfc_ifs.sv
// Input channel: one word per frame pixel, read or dispose step.
interface apfc_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic [7:0]  alpha;
  logic [17:0] pixel_index;
  modport source(output valid, mode, red, green, blue, alpha, pixel_index, input ready);
  modport sink(input valid, mode, red, green, blue, alpha, pixel_index, output ready);
endinterface

// Result channel: one word per input word.
interface apfc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;
  logic [7:0] out_alpha;
  logic       clipped;
  modport source(output valid, out_red, out_green, out_blue, out_alpha, clipped, input ready);
  modport sink(input valid, out_red, out_green, out_blue, out_alpha, clipped, output ready);
endinterface

>>> hw/rtl/apfc_ram.sv
module apfc_ram #(
  parameter int unsigned ADDR_W = 18,
  parameter int unsigned DATA_W = 32
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] waddr,
  input  logic [DATA_W-1:0] wdata,
  input  logic [ADDR_W-1:0] raddr,
  output logic [DATA_W-1:0] rdata
);

  logic [DATA_W-1:0] mem [2**ADDR_W];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> hw/rtl/apfc_div.sv
module apfc_div (
  input  logic              clk,
  input  logic              rst_n,
  input  apfc_pkg::div_ctrl_t ctrl,
  input  logic [24:0]       numer,
  input  logic [15:0]       denom,
  output logic [7:0]        quot,
  output logic              done
);

  logic [24:0] rem_r, rem_nxt;
  logic [24:0] den_r, den_nxt;
  logic [7:0]  quot_r, quot_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic        done_r, done_nxt;

  // Restoring division, one quotient bit a cycle, most significant first.
  // The quotient is known to fit in eight bits.
  always_comb begin
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (ctrl.start) begin
      rem_nxt  = numer;
      den_nxt  = {2'b00, denom, 7'b0};
      quot_nxt = '0;
      cnt_nxt  = 3'd7;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (rem_r >= den_r) begin
        rem_nxt  = rem_r - den_r;
        quot_nxt = {quot_r[6:0], 1'b1};
      end else begin
        quot_nxt = {quot_r[6:0], 1'b0};
      end
      den_nxt = den_r >> 1;
      cnt_nxt = cnt_r - 3'd1;
      if (cnt_r == 3'd0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
    cnt_r  <= cnt_nxt;
  end

  assign quot = quot_r;
  assign done = done_r;

endmodule

>>> hw/rtl/apng_frame_compositor_core.sv
// Channel   Direction  Word
// in_chan   in         mode, red, green, blue, alpha, pixel_index
// out_chan  out        out_red, out_green, out_blue, out_alpha, clipped
// APB       in/out     eight configuration registers at byte address 4*i
//
// A clipped word goes from idle straight to output; a read, a dispose step or a
// replacing frame pixel passes the lookup and calc states, and an alpha-over pixel
// also prep and the bit-serial dividers (prep writes at once at zero coverage).
// After reset a clearing pass writes zero to all 262144 canvas entries, one a
// cycle, while no word is accepted. A stalled result waits in the output
// register; the next word is accepted only once the block is back in idle.
module apng_frame_compositor_core (
  input  logic              clk,
  input  logic              rst_n,
  apfc_in_if.sink           in_chan,
  apfc_out_if.source        out_chan,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [4:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  typedef enum logic [6:0] {
    ST_CLEAR = 7'b0000001,
    ST_IDLE  = 7'b0000010,
    ST_LOOK  = 7'b0000100,
    ST_CALC  = 7'b0001000,
    ST_PREP  = 7'b0010000,
    ST_DIV   = 7'b0100000,
    ST_OUT   = 7'b1000000
  } state_t;

  localparam int unsigned AW = apfc_pkg::ADDR_W;

  state_t state_r, state_nxt;

  // Configuration registers.
  logic [9:0] cw_r, ch_r, fw_r, fh_r;
  logic [8:0] xoff_r, yoff_r;
  logic       blend_r;
  logic [1:0] disp_r;
  logic       cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cw_r    <= 10'd1;
      ch_r    <= 10'd1;
      xoff_r  <= '0;
      yoff_r  <= '0;
      fw_r    <= 10'd1;
      fh_r    <= 10'd1;
      blend_r <= 1'b0;
      disp_r  <= '0;
    end else if (cfg_we) begin
      case (paddr[4:2])
        apfc_pkg::REG_CANVAS_W: cw_r    <= pwdata[9:0];
        apfc_pkg::REG_CANVAS_H: ch_r    <= pwdata[9:0];
        apfc_pkg::REG_X_OFF:    xoff_r  <= pwdata[8:0];
        apfc_pkg::REG_Y_OFF:    yoff_r  <= pwdata[8:0];
        apfc_pkg::REG_FRAME_W:  fw_r    <= pwdata[9:0];
        apfc_pkg::REG_FRAME_H:  fh_r    <= pwdata[9:0];
        apfc_pkg::REG_BLEND:    blend_r <= pwdata[0];
        apfc_pkg::REG_DISPOSE:  disp_r  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  // Register read-back.
  always_comb begin
    case (paddr[4:2])
      apfc_pkg::REG_CANVAS_W: prdata = {22'b0, cw_r};
      apfc_pkg::REG_CANVAS_H: prdata = {22'b0, ch_r};
      apfc_pkg::REG_X_OFF:    prdata = {23'b0, xoff_r};
      apfc_pkg::REG_Y_OFF:    prdata = {23'b0, yoff_r};
      apfc_pkg::REG_FRAME_W:  prdata = {22'b0, fw_r};
      apfc_pkg::REG_FRAME_H:  prdata = {22'b0, fh_r};
      apfc_pkg::REG_BLEND:    prdata = {31'b0, blend_r};
      apfc_pkg::REG_DISPOSE:  prdata = {30'b0, disp_r};
      default:                prdata = '0;
    endcase
  end

  // Effective sides.
  logic [9:0] cw_s, ch_s, fw_s, fh_s;
  assign cw_s = apfc_pkg::side_sat(cw_r);
  assign ch_s = apfc_pkg::side_sat(ch_r);
  assign fw_s = (apfc_pkg::side_sat(fw_r) == 10'd0) ? 10'd1 : apfc_pkg::side_sat(fw_r);
  assign fh_s = (apfc_pkg::side_sat(fh_r) == 10'd0) ? 10'd1 : apfc_pkg::side_sat(fh_r);

  // Region position and its canvas address.
  logic [8:0]  col_r, col_nxt, row_r, row_nxt;
  logic [9:0]  cx, cy;
  logic [19:0] row_base, lim;
  logic [19:0] reg_addr;
  logic        reg_inside;

  assign cx         = {1'b0, xoff_r} + {1'b0, col_r};
  assign cy         = {1'b0, yoff_r} + {1'b0, row_r};
  assign row_base   = cy * cw_s;
  assign reg_addr   = row_base + {10'b0, cx};
  assign reg_inside = (cx < cw_s) && (cy < ch_s);
  assign lim        = cw_s * ch_s;

  // Word registers.
  logic [1:0]  mode_r;
  logic [7:0]  src_r [3];
  logic [7:0]  a_r;
  logic [AW-1:0] addr_r;
  logic [31:0] res_r;
  logic        clip_r;
  logic [15:0] sa_r [3];
  logic [15:0] cd_r [3];
  logic [15:0] n_r;
  logic [23:0] old_r;
  logic [7:0]  ia_r;

  // Clearing pass counter.
  logic [AW-1:0] clr_r;

  // Memories.
  logic          cv_we, sv_we;
  logic [AW-1:0] cv_waddr;
  logic [31:0]   cv_wdata;
  logic [31:0]   cv_q, sv_q;

  apfc_ram #(.ADDR_W(AW), .DATA_W(apfc_pkg::PIX_W)) u_canvas (
    .clk   (clk),
    .we    (cv_we),
    .waddr (cv_waddr),
    .wdata (cv_wdata),
    .raddr (addr_r),
    .rdata (cv_q)
  );

  apfc_ram #(.ADDR_W(AW), .DATA_W(apfc_pkg::PIX_W)) u_saved (
    .clk   (clk),
    .we    (sv_we),
    .waddr (addr_r),
    .wdata (cv_q),
    .raddr (addr_r),
    .rdata (sv_q)
  );

  // Dividers, one per colour channel.
  apfc_pkg::div_ctrl_t div_ctrl;
  logic [24:0] numer [3];
  logic [7:0]  quot [3];
  logic        div_done [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    assign numer[i] = 25'({sa_r[i], 8'b0}) - 25'(sa_r[i]) + 25'(cd_r[i] * ia_r);
    apfc_div u_div (
      .clk   (clk),
      .rst_n (rst_n),
      .ctrl  (div_ctrl),
      .numer (numer[i]),
      .denom (n_r),
      .quot  (quot[i]),
      .done  (div_done[i])
    );
  end

  // New alpha is n / 255, exact for n below 65280.
  logic [16:0] aq_sum;
  logic [7:0]  alpha_new;
  assign aq_sum    = {1'b0, n_r} + 17'd1 + {9'b0, n_r[15:8]};
  assign alpha_new = aq_sum[15:8];

  logic out_valid_r;
  logic accept;
  assign in_chan.ready = (state_r == ST_IDLE);
  assign accept        = in_chan.valid && in_chan.ready;

  // Region counter advances on every frame pixel and dispose step.
  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (accept && (in_chan.mode == apfc_pkg::MODE_FRAME ||
                   in_chan.mode == apfc_pkg::MODE_DISPOSE)) begin
      if ({1'b0, col_r} + 10'd1 >= fw_s) begin
        col_nxt = '0;
        if ({1'b0, row_r} + 10'd1 >= fh_s) begin
          row_nxt = '0;
        end else begin
          row_nxt = row_r + 9'd1;
        end
      end else begin
        col_nxt = col_r + 9'd1;
      end
    end
  end

  // Sequencer and memory write controls.
  always_comb begin
    state_nxt     = state_r;
    cv_we         = 1'b0;
    cv_waddr      = addr_r;
    cv_wdata      = '0;
    sv_we         = 1'b0;
    div_ctrl.start = 1'b0;
    case (state_r)
      ST_CLEAR: begin
        cv_we    = 1'b1;
        cv_waddr = clr_r;
        if (clr_r == '1) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_chan.mode)
            apfc_pkg::MODE_FRAME, apfc_pkg::MODE_DISPOSE:
              state_nxt = reg_inside ? ST_LOOK : ST_OUT;
            apfc_pkg::MODE_READ:
              state_nxt = ({2'b0, in_chan.pixel_index} < lim) ? ST_LOOK : ST_OUT;
            default: state_nxt = ST_OUT;
          endcase
        end
      end
      ST_LOOK: state_nxt = ST_CALC;
      ST_CALC: begin
        state_nxt = ST_OUT;
        case (mode_r)
          apfc_pkg::MODE_FRAME: begin
            sv_we = (disp_r == apfc_pkg::DISP_RESTORE);
            if (blend_r) begin
              state_nxt = ST_PREP;
            end else begin
              cv_we    = 1'b1;
              cv_wdata = {a_r, src_r[2], src_r[1], src_r[0]};
            end
          end
          apfc_pkg::MODE_DISPOSE: begin
            if (disp_r == apfc_pkg::DISP_CLEAR) begin
              cv_we = 1'b1;
            end else if (disp_r == apfc_pkg::DISP_RESTORE) begin
              cv_we    = 1'b1;
              cv_wdata = sv_q;
            end
          end
          default: ;
        endcase
      end
      ST_PREP: begin
        if (n_r == 16'd0) begin
          cv_we     = 1'b1;
          cv_wdata  = {8'b0, old_r};
          state_nxt = ST_OUT;
        end else begin
          div_ctrl.start = 1'b1;
          state_nxt      = ST_DIV;
        end
      end
      ST_DIV: begin
        if (div_done[0]) begin
          cv_we     = 1'b1;
          cv_wdata  = {alpha_new, quot[2], quot[1], quot[0]};
          state_nxt = ST_OUT;
        end
      end
      ST_OUT: begin
        if (!out_valid_r || out_chan.ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      col_r       <= '0;
      row_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      col_r   <= col_nxt;
      row_r   <= row_nxt;
      if (state_r == ST_CLEAR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (state_r == ST_OUT && (!out_valid_r || out_chan.ready)) begin
        out_valid_r <= 1'b1;
      end else if (out_chan.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Word datapath.
  always_ff @(posedge clk) begin
    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          mode_r   <= in_chan.mode;
          src_r[0] <= in_chan.red;
          src_r[1] <= in_chan.green;
          src_r[2] <= in_chan.blue;
          a_r      <= in_chan.alpha;
          res_r    <= '0;
          clip_r   <= 1'b1;
          if (in_chan.mode == apfc_pkg::MODE_READ) begin
            addr_r <= in_chan.pixel_index;
          end else begin
            addr_r <= reg_addr[AW-1:0];
          end
        end
      end
      ST_CALC: begin
        clip_r <= 1'b0;
        old_r  <= cv_q[23:0];
        ia_r   <= 8'd255 - a_r;
        n_r    <= 16'({a_r, 8'b0} - {8'b0, a_r}) + 16'(cv_q[31:24] * (8'd255 - a_r));
        for (int i = 0; i < 3; i++) begin
          sa_r[i] <= src_r[i] * a_r;
          cd_r[i] <= cv_q[8*i +: 8] * cv_q[31:24];
        end
        case (mode_r)
          apfc_pkg::MODE_FRAME:   res_r <= {a_r, src_r[2], src_r[1], src_r[0]};
          apfc_pkg::MODE_DISPOSE: begin
            if (disp_r == apfc_pkg::DISP_CLEAR) begin
              res_r <= '0;
            end else if (disp_r == apfc_pkg::DISP_RESTORE) begin
              res_r <= sv_q;
            end else begin
              res_r <= cv_q;
            end
          end
          default: res_r <= cv_q;
        endcase
      end
      ST_PREP: res_r <= {8'b0, old_r};
      ST_DIV:  res_r <= {alpha_new, quot[2], quot[1], quot[0]};
      default: ;
    endcase
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (state_r == ST_OUT && (!out_valid_r || out_chan.ready)) begin
      out_chan.out_red   <= res_r[7:0];
      out_chan.out_green <= res_r[15:8];
      out_chan.out_blue  <= res_r[23:16];
      out_chan.out_alpha <= res_r[31:24];
      out_chan.clipped   <= clip_r;
    end
  end

  assign out_chan.valid = out_valid_r;

endmodule
